// File: rtl/rde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg
// Widths, register indexes, reset values and alphabet helpers for the
// radix digit emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int MAX_RADIX  = 16;
  localparam int MAX_DIGITS = 64;

  localparam int VALUE_W   = 64;
  localparam int CHAR_W    = 8;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CNT_W     = 7;
  localparam int ALPH_W    = 2 * VALUE_W;
  localparam int ADDR_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CFG_IDX_W = 2;

  // Quotient bits retired per clock in the divider, and passes per digit.
  localparam int DIV_BITS   = 8;
  localparam int DIV_PASSES = VALUE_W / DIV_BITS;
  localparam int PASS_W     = (DIV_PASSES > 1) ? $clog2(DIV_PASSES) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPH_LOW   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPH_HIGH  = CFG_IDX_W'(2);

  localparam logic [RADIX_W-1:0] RADIX_RST     = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
  localparam logic [VALUE_W-1:0] ALPH_LOW_RST  = 64'd3978425819141910832;
  localparam logic [VALUE_W-1:0] ALPH_HIGH_RST = 64'd14648;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Character for digit d: byte d of alphabet_high:alphabet_low.
  function automatic logic [CHAR_W-1:0] alpha_char(logic [ALPH_W-1:0] alph,
                                                   logic [DIGIT_W-1:0] d);
    return alph[{d, 3'b000} +: CHAR_W];
  endfunction

  // Radix in range, no sign or NUL characters, no repeats among the
  // characters in use.
  function automatic logic alphabet_ok(logic [RADIX_W-1:0] rdx,
                                       logic [ALPH_W-1:0] alph);
    logic              ok;
    logic [CHAR_W-1:0] ca;
    ok = (rdx >= RADIX_MIN) && (rdx <= RADIX_W'(MAX_RADIX));
    for (int a = 0; a < MAX_RADIX; a++) begin
      ca = alph[a*CHAR_W +: CHAR_W];
      if (a < int'(rdx)) begin
        if (ca == CHAR_NUL || ca == CHAR_PLUS || ca == CHAR_MINUS) ok = 1'b0;
        for (int b = a + 1; b < MAX_RADIX; b++) begin
          if (b < int'(rdx) && alph[b*CHAR_W +: CHAR_W] == ca) ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

// File: rtl/radix_digit_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Writes a 64-bit unsigned value as digit characters in a configurable base.
// ----------------------------------------------------------------------------
// One input transfer yields one output transfer per digit character, most
// significant first; the final one has is_last set and carries the character
// count. A zero value gives the first alphabet character once. If the
// alphabet is unusable (radix outside 2..16, a '+', '-' or NUL among the
// characters in use, or a repeated character) the value gives one transfer
// with has_character clear, is_last set and a count of zero. Digits come
// from a restoring divider that retires 8 quotient bits per clock and are
// kept in a 64-entry digit store with a registered read port. They are read
// back in reverse, one character read at a time, and each read waits for
// room at the output. A value holds the input off from its transfer until
// its last digit has been read from the store, and its last character
// reaches the output at the edge where the next value can be taken.
// The next value is taken as soon as the last character has been read out,
// even while that character still waits at the output. Configuration writes
// take effect at once and must only happen while the block is idle; index 3
// is ignored.
// ----------------------------------------------------------------------------
module radix_digit_emitter import rde_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [VALUE_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [VALUE_W-1:0]   value_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CHAR_W-1:0]    character_o,
  output logic                 has_character_o,
  output logic                 is_last_o,
  output logic [CNT_W-1:0]     char_count_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_ERR  = 2'd3;

  // Configuration registers
  logic [RADIX_W-1:0] radix_q;
  logic [VALUE_W-1:0] alph_low_q, alph_high_q;
  logic [ALPH_W-1:0]  alph;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q     <= RADIX_RST;
      alph_low_q  <= ALPH_LOW_RST;
      alph_high_q <= ALPH_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIX:     radix_q     <= cfg_wdata_i[RADIX_W-1:0];
        CFG_ALPH_LOW:  alph_low_q  <= cfg_wdata_i;
        CFG_ALPH_HIGH: alph_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign alph = {alph_high_q, alph_low_q};

  // Control state
  logic [1:0]         state_q, state_d;
  logic [PASS_W-1:0]  pass_q, pass_d;
  logic [CNT_W-1:0]   ndig_q, ndig_d;     // digits produced so far
  logic [CNT_W-1:0]   ptr_q, ptr_d;       // digits still to read back
  logic               rd_pend_q, rd_pend_d;
  logic               rd_last_q, rd_last_d;
  logic               out_valid_q, out_valid_d;

  // Divider datapath
  logic [VALUE_W-1:0] quot_q, quot_d, quot_nx;
  logic [RADIX_W-1:0] rem_q, rem_d, rem_nx;

  // Digit store
  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [DIGIT_W-1:0] mem_wdata, mem_rdata_q;

  // Output payload registers
  logic [CHAR_W-1:0]  char_q;
  logic               has_q, last_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   rd_cnt_q;

  logic in_xfer, out_free, load_rd, load_err, last_pass;
  logic [CNT_W-1:0] ptr_m1;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  // Output slot is empty by the next edge
  assign out_free   = !out_valid_q || out_ready_i;
  assign last_pass  = (pass_q == PASS_W'(DIV_PASSES - 1));
  assign ptr_m1     = ptr_q - CNT_W'(1);

  // Restoring division: shift the working value up through the partial
  // remainder, shift quotient bits in at the bottom.
  always_comb begin
    logic [RADIX_W-1:0] r;
    logic [VALUE_W-1:0] w;
    r = rem_q;
    w = quot_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[RADIX_W-2:0], w[VALUE_W-1]};
      w = {w[VALUE_W-2:0], 1'b0};
      if (r >= radix_q) begin
        r    = r - radix_q;
        w[0] = 1'b1;
      end
    end
    rem_nx  = r;
    quot_nx = w;
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    ndig_d      = ndig_q;
    ptr_d       = ptr_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    rd_last_d   = rd_last_q;
    mem_we      = 1'b0;
    mem_waddr   = ndig_q[ADDR_W-1:0];
    mem_wdata   = rem_nx[DIGIT_W-1:0];
    mem_re      = 1'b0;
    mem_raddr   = ptr_m1[ADDR_W-1:0];
    load_err    = 1'b0;
    // a pending read always lands in the output slot next edge
    load_rd     = rd_pend_q;
    rd_pend_d   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          ndig_d = '0;
          if (alphabet_ok(radix_q, alph)) begin
            quot_d  = value_i;
            rem_d   = '0;
            pass_d  = '0;
            state_d = S_DIV;
          end else begin
            state_d = S_ERR;
          end
        end
      end
      S_DIV: begin
        quot_d = quot_nx;
        rem_d  = rem_nx;
        pass_d = pass_q + PASS_W'(1);
        if (last_pass) begin
          // store the digit, restart the remainder for the next one
          mem_we = 1'b1;
          ndig_d = ndig_q + CNT_W'(1);
          rem_d  = '0;
          pass_d = '0;
          if (quot_nx == '0 || ndig_q == CNT_W'(MAX_DIGITS - 1)) begin
            ptr_d   = ndig_q + CNT_W'(1);
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!rd_pend_q && out_free) begin
          mem_re    = 1'b1;
          rd_pend_d = 1'b1;
          rd_last_d = (ptr_q == CNT_W'(1));
          ptr_d     = ptr_m1;
          if (ptr_q == CNT_W'(1)) state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (!rd_pend_q && out_free) begin
          load_err = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load_rd || load_err) out_valid_d = 1'b1;
    else if (out_ready_i)    out_valid_d = 1'b0;
    else                     out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= '0;
      ndig_q      <= '0;
      ptr_q       <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
      quot_q      <= '0;
      rem_q       <= '0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      ndig_q      <= ndig_d;
      ptr_q       <= ptr_d;
      rd_pend_q   <= rd_pend_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
      quot_q      <= quot_d;
      rem_q       <= rem_d;
    end
  end

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
      rd_cnt_q    <= ndig_q;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (load_rd) begin
      char_q <= alpha_char(alph, mem_rdata_q);
      has_q  <= 1'b1;
      last_q <= rd_last_q;
      cnt_q  <= rd_last_q ? rd_cnt_q : '0;
    end else if (load_err) begin
      char_q <= '0;
      has_q  <= 1'b0;
      last_q <= 1'b1;
      cnt_q  <= '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign character_o     = char_q;
  assign has_character_o = has_q;
  assign is_last_o       = last_q;
  assign char_count_o    = cnt_q;

`ifndef NO_ASSERTIONS
  // A read in flight always finds the output slot empty.
  a_pend_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("digit read pending while output slot is occupied");

  // Partial remainder stays below the radix while dividing.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < radix_q))
    else $error("divider remainder out of range");

  // Digit count never runs past the store while dividing.
  a_ndig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (ndig_q < CNT_W'(MAX_DIGITS)))
    else $error("digit count past store depth");

  // A result without a character is the lone error result.
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_character_o) |-> (is_last_o && char_count_o == '0))
    else $error("malformed error result");

  // A final character result carries a nonzero count.
  a_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_character_o && is_last_o) |-> (char_count_o != '0))
    else $error("final character without a count");
`endif

endmodule

// File: sim/radix_digit_emitter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_tb
// Self-checking bench for the radix digit emitter. Values stream in over a
// valid/ready channel and every digit character coming out is compared with
// a software digit writer kept in a small scoreboard. The bench runs through
// decimal, binary, hex, custom and broken alphabets, with random stalls on
// both channels and one long output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module radix_digit_emitter_tb;
  import rde_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // Long enough for a 64-digit binary value to pass through the block.
  localparam int unsigned TAIL_CYCLES = 700;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD = 600;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 30;
  localparam int unsigned BROKEN_ITEMS = 8;

  // Index 3 decodes to no register; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  // Ways to spoil an alphabet in the random part.
  typedef enum int {
    BREAK_RADIX,
    BREAK_PLUS,
    BREAK_MINUS,
    BREAK_NUL,
    BREAK_REPEAT
  } breakage_e;

  // One output transfer.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              has_character;
    logic              is_last;
    logic [CNT_W-1:0]  char_count;
  } glyph_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the registers, turns each accepted value into the
  // characters it must produce and checks them in order.
  // --------------------------------------------------------------------------
  class digit_scoreboard;
    glyph_t            pending_q[$];
    int unsigned       errors;
    logic [RADIX_W-1:0] base;
    logic [ALPH_W-1:0]  alphabet;

    function new();
      errors   = 0;
      base     = RADIX_RST;
      alphabet = {ALPH_HIGH_RST, ALPH_LOW_RST};
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
      case (idx)
        CFG_RADIX:     base = data[RADIX_W-1:0];
        CFG_ALPH_LOW:  alphabet[VALUE_W-1:0] = data;
        CFG_ALPH_HIGH: alphabet[ALPH_W-1:VALUE_W] = data;
        default: ;
      endcase
    endfunction

    function logic [CHAR_W-1:0] glyph_of(int k);
      return alphabet[k*CHAR_W +: CHAR_W];
    endfunction

    function bit base_usable();
      logic [CHAR_W-1:0] c;
      if (base < RADIX_MIN || base > RADIX_W'(MAX_RADIX)) return 1'b0;
      for (int a = 0; a < int'(base); a++) begin
        c = glyph_of(a);
        if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS) return 1'b0;
        for (int b = a + 1; b < int'(base); b++) begin
          if (glyph_of(b) == c) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_value(logic [VALUE_W-1:0] v);
      logic [DIGIT_W-1:0] digits [MAX_DIGITS];
      logic [VALUE_W-1:0] rest;
      glyph_t             g;
      int                 n;
      g = '0;
      if (!base_usable()) begin
        // Unusable alphabet: a single empty, final transfer.
        g.is_last = 1'b1;
        pending_q.push_back(g);
        return;
      end
      rest = v;
      n    = 0;
      if (rest == '0) begin
        digits[0] = '0;
        n = 1;
      end
      while (rest != '0 && n < MAX_DIGITS) begin
        digits[n] = DIGIT_W'(rest % VALUE_W'(base));
        rest      = rest / VALUE_W'(base);
        n++;
      end
      for (int k = 0; k < n; k++) begin
        g.character     = glyph_of(int'(digits[n-1-k]));
        g.has_character = 1'b1;
        g.is_last       = (k == n - 1);
        g.char_count    = (k == n - 1) ? CNT_W'(n) : '0;
        pending_q.push_back(g);
      end
    endfunction

    function void compare_field(string name, logic [VALUE_W-1:0] want,
                                logic [VALUE_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_glyph(glyph_t got);
      glyph_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer: expected none, actual char %0h has %0b last %0b count %0d",
                 $time, got.character, got.has_character, got.is_last, got.char_count);
        return;
      end
      want = pending_q.pop_front();
      compare_field("character", want.character, got.character);
      compare_field("has_character", want.has_character, got.has_character);
      compare_field("is_last", want.is_last, got.is_last);
      compare_field("char_count", want.char_count, got.char_count);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT ports and shared bench state
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VALUE_W-1:0]   cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [VALUE_W-1:0]   value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [CHAR_W-1:0]    character_o;
  logic                 has_character_o;
  logic                 is_last_o;
  logic [CNT_W-1:0]     char_count_o;

  digit_scoreboard    sb;
  logic [VALUE_W-1:0] send_q[$];     // values waiting to be offered
  int unsigned        in_flight;     // queued or on the wire, not yet taken
  int unsigned        idle_pct;      // chance per cycle to start an idle burst
  bit                 long_hold_req; // ask the receiver for one long hold-off

  radix_digit_emitter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .character_o     (character_o),
    .has_character_o (has_character_o),
    .is_last_o       (is_last_o),
    .char_count_o    (char_count_o)
  );

  // --------------------------------------------------------------------------
  // Value sender: hold valid and payload until the transfer, note each
  // accepted value in the scoreboard, insert idle bursts between values.
  // --------------------------------------------------------------------------
  initial begin : sender
    int unsigned gap;
    in_valid_i <= 1'b0;
    value_i    <= '0;
    gap = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      // Hold the current offer until it is taken.
      if (in_valid_i && !in_ready_o) continue;
      if (in_valid_i) begin
        sb.note_value(value_i);
        in_flight--;
      end
      if (gap == 0 && idle_pct != 0 && $urandom_range(99) < idle_pct)
        gap = $urandom_range(1, 7);
      // Decide the next cycle with one assignment to valid only.
      if (gap > 0) begin
        gap--;
        in_valid_i <= 1'b0;
      end else if (send_q.size() > 0) begin
        in_valid_i <= 1'b1;
        value_i    <= send_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Character receiver: check every output transfer, stall in random bursts
  // and serve the long hold-off when the main sequence asks for it.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned stall;
    int unsigned hold;
    glyph_t      got;
    out_ready_i <= 1'b0;
    stall = 0;
    hold  = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.character     = character_o;
        got.has_character = has_character_o;
        got.is_last       = is_last_o;
        got.char_count    = char_count_o;
        sb.check_glyph(got);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall = $urandom_range(1, 7) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    do begin
      @(posedge clk_i);
      cycles++;
    end while (cycles < CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles", $time, cycles);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Configuration and sequencing helpers
  // --------------------------------------------------------------------------
  // Drive one register write; the mirror is updated at once since the block
  // is idle whenever this is called.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
  endtask

  task automatic cfg_close();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Load base and both alphabet words; junk in the unused radix bits
  // must be dropped by the block.
  task automatic set_alphabet(input int unsigned r, input logic [VALUE_W-1:0] lo,
                              input logic [VALUE_W-1:0] hi);
    logic [VALUE_W-1:0] w;
    w = {$urandom, $urandom};
    w[RADIX_W-1:0] = RADIX_W'(r);
    cfg_write(CFG_RADIX, w);
    cfg_write(CFG_ALPH_LOW, lo);
    cfg_write(CFG_ALPH_HIGH, hi);
    cfg_close();
  endtask

  task automatic offer(input logic [VALUE_W-1:0] v);
    send_q.push_back(v);
    in_flight++;
  endtask

  // Wait until every value is taken and every character has come out.
  task automatic drain();
    do @(posedge clk_i);
    while (in_flight != 0 || sb.pending_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Distinct characters in use, none of them NUL or a sign; bytes past the
  // base are left random since the block must ignore them.
  function automatic logic [ALPH_W-1:0] random_alphabet(int r);
    logic [ALPH_W-1:0]  a;
    logic [CHAR_W-1:0]  c;
    bit                 fresh;
    a = {$urandom, $urandom, $urandom, $urandom};
    for (int k = 0; k < r; k++) begin
      do begin
        c = CHAR_W'($urandom);
        fresh = (c != CHAR_NUL && c != CHAR_PLUS && c != CHAR_MINUS);
        for (int j = 0; j < k; j++) begin
          if (a[j*CHAR_W +: CHAR_W] == c) fresh = 1'b0;
        end
      end while (!fresh);
      a[k*CHAR_W +: CHAR_W] = c;
    end
    return a;
  endfunction

  // Mostly short values so that most items stay quick, some zeros and
  // all-ones.
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [ALPH_W-1:0]  alph;
    breakage_e          kind;
    int                 r;
    int                 i;
    int                 j;
    int unsigned        items;

    sb = new();
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_RADIX;
    cfg_wdata_i <= '0;
    idle_pct      = 20;
    long_hold_req = 1'b0;
    in_flight     = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Decimal with the reset alphabet: zero, one, digit edges, extremes.
    offer('0);
    offer(64'd1);
    offer(64'd9);
    offer(64'd10);
    offer('1);
    offer(64'h8000_0000_0000_0000);
    drain();

    // Binary: all-ones fills the whole digit store.
    set_alphabet(2, ALPH_LOW_RST, ALPH_HIGH_RST);
    offer('0);
    offer('1);
    offer(64'd1);
    drain();

    // Hex with a full 16-character alphabet.
    set_alphabet(16, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    offer(64'hFEDC_BA98_7654_3210);
    offer('1);
    offer('0);
    drain();

    // Base out of range on both sides.
    set_alphabet(1, ALPH_LOW_RST, ALPH_HIGH_RST);
    offer(64'd42);
    drain();
    set_alphabet(0, ALPH_LOW_RST, ALPH_HIGH_RST);
    offer(64'd42);
    drain();
    set_alphabet(17, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938);
    offer(64'd42);
    drain();
    set_alphabet(31, ALPH_LOW_RST, ALPH_HIGH_RST);
    offer('1);
    drain();

    // Plus sign among the characters in use.
    lo = ALPH_LOW_RST;
    lo[3*CHAR_W +: CHAR_W] = CHAR_PLUS;
    set_alphabet(10, lo, ALPH_HIGH_RST);
    offer(64'd123);
    drain();

    // Minus sign on the last character in use.
    hi = ALPH_HIGH_RST;
    hi[1*CHAR_W +: CHAR_W] = CHAR_MINUS;
    set_alphabet(10, ALPH_LOW_RST, hi);
    offer(64'd123);
    drain();

    // NUL as the first character.
    lo = ALPH_LOW_RST;
    lo[0 +: CHAR_W] = CHAR_NUL;
    set_alphabet(10, lo, ALPH_HIGH_RST);
    offer(64'd0);
    drain();

    // Repeated character.
    lo = ALPH_LOW_RST;
    lo[7*CHAR_W +: CHAR_W] = 8'h32;
    set_alphabet(10, lo, ALPH_HIGH_RST);
    offer(64'd777);
    drain();

    // A minus sign on the last character in use spoils the base-9 alphabet;
    // also poke the unused index, which must leave every register alone.
    hi = ALPH_HIGH_RST;
    hi[0 +: CHAR_W] = CHAR_MINUS;
    cfg_write(CFG_UNUSED, {$urandom, $urandom});
    set_alphabet(9, ALPH_LOW_RST, hi);
    offer(64'd8);
    offer('1);
    drain();

    // Random phases: mostly valid alphabets with random content, a couple
    // of broken ones, one long output hold-off, and a calm final stretch.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      r     = $urandom_range(2, 16);
      alph  = random_alphabet(r);
      items = PHASE_ITEMS;
      if (p == 4 || p == 8) begin
        items = BROKEN_ITEMS;
        kind  = breakage_e'($urandom_range(BREAK_RADIX, BREAK_REPEAT));
        i     = $urandom_range(0, r - 1);
        case (kind)
          BREAK_RADIX:  r = $urandom_range(0, 1) ? $urandom_range(0, 1)
                                                 : $urandom_range(17, 31);
          BREAK_PLUS:   alph[i*CHAR_W +: CHAR_W] = CHAR_PLUS;
          BREAK_MINUS:  alph[i*CHAR_W +: CHAR_W] = CHAR_MINUS;
          BREAK_NUL:    alph[i*CHAR_W +: CHAR_W] = CHAR_NUL;
          BREAK_REPEAT: begin
            j = (i + 1 + $urandom_range(0, r - 2)) % r;
            alph[j*CHAR_W +: CHAR_W] = alph[i*CHAR_W +: CHAR_W];
          end
          default: ;
        endcase
      end
      set_alphabet(r, alph[VALUE_W-1:0], alph[ALPH_W-1:VALUE_W]);

      // Alternate idling and clean stretches; none at the very end.
      idle_pct = (p % 2 == 0) ? 25 : 0;
      if (p == RANDOM_PHASES - 1) idle_pct = 0;
      // Back the block up: hold the output while values keep coming.
      if (p == 2) begin
        idle_pct = 0;
        long_hold_req = 1'b1;
      end
      for (int n = 0; n < items; n++) offer(random_value());
      drain();
    end

    // Let any stray transfer show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.pending_q.size() != 0)
      $display("%0t: %0d expected transfers never arrived", $time, sb.pending_q.size());
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
